// ===== hdl/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg: shared types and constants of the packet reorder release block
// Field widths, run cap, register map, sequencer states and slot store types.
// ----------------------------------------------------------------------------
package prr_pkg;

    // Payload field widths
    parameter int SEQ_W = 16;
    parameter int WCNT_W = 8;
    parameter int HND_W = 32;

    // Reorder window (slot store depth) default
    parameter int WINDOW_DEFAULT = 64;

    // At most this many results per accepted packet
    parameter int RUN_CAP = 64;
    parameter int RES_CNT_W = $clog2(RUN_CAP + 1);

    // Configuration port
    parameter int PADDR_W = 2;
    parameter int PDATA_W = 32;
    parameter logic [PADDR_W-1:0] REG_TOTAL_ADDR = 2'd0;
    parameter logic [SEQ_W-1:0] TOTAL_RESET = 16'hFFFF;

    // Result status codes
    parameter logic ST_RELEASED = 1'b0;
    parameter logic ST_DROPPED = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CLASS,
        S_ERD,
        S_DRQ,
        S_DRD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              present;
        logic [WCNT_W-1:0] count;
        logic [HND_W-1:0]  handle;
    } t_slot_entry;

    typedef struct packed {
        logic        we;
        logic        re;
        t_slot_entry wdata;
    } t_mem_cmd;

endpackage

// ===== hdl/prr_if.sv =====
// ----------------------------------------------------------------------------
// prr_if: valid/ready channels of the packet reorder release block
// Packet input channel and result output channel.
// ----------------------------------------------------------------------------
interface prr_in_if;
    logic                       valid;
    logic                       ready;
    logic [prr_pkg::SEQ_W-1:0]  seq_number;
    logic [prr_pkg::WCNT_W-1:0] word_count;
    logic [prr_pkg::HND_W-1:0]  payload_handle;

    modport source (output valid, seq_number, word_count, payload_handle, input ready);
    modport sink (input valid, seq_number, word_count, payload_handle, output ready);
endinterface

interface prr_out_if;
    logic                       valid;
    logic                       ready;
    logic [prr_pkg::SEQ_W-1:0]  out_seq;
    logic [prr_pkg::WCNT_W-1:0] out_count;
    logic [prr_pkg::HND_W-1:0]  out_handle;
    logic                       status;
    logic                       last;

    modport source (output valid, out_seq, out_count, out_handle, status, last, input ready);
    modport sink (input valid, out_seq, out_count, out_handle, status, last, output ready);
endinterface

// ===== hdl/prr_apb_regs.sv =====
// ----------------------------------------------------------------------------
// prr_apb_regs: configuration register file
// Holds total_packets, written and read over an APB-style port.
// ----------------------------------------------------------------------------
module prr_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prr_pkg::PADDR_W-1:0] paddr,
    input  logic [prr_pkg::PDATA_W-1:0] pwdata,
    output logic [prr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [prr_pkg::SEQ_W-1:0]   o_total
);

    logic [prr_pkg::SEQ_W-1:0] r_total;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && (paddr == prr_pkg::REG_TOTAL_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= prr_pkg::TOTAL_RESET;
        end else if (wr_en) begin
            r_total <= pwdata[prr_pkg::SEQ_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr)
            prr_pkg::REG_TOTAL_ADDR: begin
                prdata = {{(prr_pkg::PDATA_W - prr_pkg::SEQ_W){1'b0}}, r_total};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_total = r_total;

endmodule

// ===== hdl/prr_slot_mem.sv =====
// ----------------------------------------------------------------------------
// prr_slot_mem: reorder slot store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module prr_slot_mem #(
    parameter int DEPTH = prr_pkg::WINDOW_DEFAULT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  prr_pkg::t_mem_cmd    i_cmd,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  logic [ADDR_W-1:0]    i_raddr,
    output prr_pkg::t_slot_entry o_rdata
);

    prr_pkg::t_slot_entry r_mem [DEPTH];
    prr_pkg::t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_waddr] <= i_cmd.wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/prr_ctrl.sv =====
// ----------------------------------------------------------------------------
// prr_ctrl: reorder sequencer
// Classifies each packet, stores early ones, drains in-order runs.
// ----------------------------------------------------------------------------
module prr_ctrl #(
    parameter int WINDOW = prr_pkg::WINDOW_DEFAULT,
    localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [prr_pkg::SEQ_W-1:0] i_total,
    prr_in_if.sink                    i_in,
    prr_out_if.source                 o_out,
    output prr_pkg::t_mem_cmd         o_mem_cmd,
    output logic [ADDR_W-1:0]         o_waddr,
    output logic [ADDR_W-1:0]         o_raddr,
    input  prr_pkg::t_slot_entry      i_rdata
);

    localparam int SW = prr_pkg::SEQ_W;
    localparam int CW = prr_pkg::WCNT_W;
    localparam int HW = prr_pkg::HND_W;
    localparam int RW = prr_pkg::RES_CNT_W;

    prr_pkg::t_state r_state, n_state;

    logic [SW-1:0]     r_seq, n_seq;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [HW-1:0]     r_hnd, n_hnd;
    logic [SW-1:0]     r_ne, n_ne;
    logic [ADDR_W-1:0] r_eslot, n_eslot;
    logic [ADDR_W-1:0] r_slot, n_slot;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [RW-1:0]     r_nres, n_nres;

    logic          r_pend_v, n_pend_v;
    logic [SW-1:0] r_pend_seq, n_pend_seq;
    logic [CW-1:0] r_pend_cnt, n_pend_cnt;
    logic [HW-1:0] r_pend_hnd, n_pend_hnd;
    logic          r_pend_st, n_pend_st;

    logic          r_out_v;
    logic [SW-1:0] r_out_seq;
    logic [CW-1:0] r_out_cnt;
    logic [HW-1:0] r_out_hnd;
    logic          r_out_st;
    logic          r_out_last;

    logic              accept;
    logic              push;
    logic              push_last;
    logic              push_ok;
    logic [SW-1:0]     diff;
    logic              is_drop;
    logic              is_hit;
    logic [ADDR_W:0]   early_sum;
    logic [ADDR_W-1:0] early_slot;
    logic [ADDR_W-1:0] eslot_inc;
    logic              can_drain;

    assign i_in.ready = (r_state == prr_pkg::S_IDLE);
    assign accept = i_in.valid && i_in.ready;
    assign push_ok = !r_out_v || o_out.ready;

    // Classification of the held packet
    assign diff = r_seq - r_ne;
    assign is_drop = (r_seq >= i_total) || (r_seq < r_ne) || (diff >= SW'(WINDOW));
    assign is_hit = (r_seq == r_ne);
    assign early_sum = {1'b0, r_eslot} + {1'b0, diff[ADDR_W-1:0]};
    assign early_slot = (early_sum >= (ADDR_W + 1)'(WINDOW))
                      ? ADDR_W'(early_sum - (ADDR_W + 1)'(WINDOW))
                      : early_sum[ADDR_W-1:0];
    assign eslot_inc = (r_eslot == ADDR_W'(WINDOW - 1)) ? '0 : r_eslot + 1'b1;
    assign can_drain = (r_nres < RW'(prr_pkg::RUN_CAP)) && (r_ne < i_total);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prr_pkg::S_CLEAR: begin
                if (r_clr == ADDR_W'(WINDOW - 1)) begin
                    n_state = prr_pkg::S_IDLE;
                end
            end
            prr_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = prr_pkg::S_CLASS;
                end
            end
            prr_pkg::S_CLASS: begin
                n_state = (is_drop || is_hit) ? prr_pkg::S_DRQ : prr_pkg::S_ERD;
            end
            prr_pkg::S_ERD: begin
                n_state = prr_pkg::S_DRQ;
            end
            prr_pkg::S_DRQ: begin
                n_state = can_drain ? prr_pkg::S_DRD : prr_pkg::S_FIN;
            end
            prr_pkg::S_DRD: begin
                if (!i_rdata.present) begin
                    n_state = prr_pkg::S_FIN;
                end else if (!r_pend_v || push_ok) begin
                    n_state = prr_pkg::S_DRQ;
                end
            end
            prr_pkg::S_FIN: begin
                if (!r_pend_v || push_ok) begin
                    n_state = prr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = prr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_seq = r_seq;
        n_cnt = r_cnt;
        n_hnd = r_hnd;
        n_ne = r_ne;
        n_eslot = r_eslot;
        n_slot = r_slot;
        n_clr = r_clr;
        n_nres = r_nres;
        n_pend_v = r_pend_v;
        n_pend_seq = r_pend_seq;
        n_pend_cnt = r_pend_cnt;
        n_pend_hnd = r_pend_hnd;
        n_pend_st = r_pend_st;
        o_mem_cmd = '0;
        o_waddr = r_eslot;
        o_raddr = r_eslot;
        push = 1'b0;
        push_last = 1'b0;
        unique case (r_state)
            prr_pkg::S_CLEAR: begin
                o_mem_cmd.we = 1'b1;
                o_waddr = r_clr;
                n_clr = r_clr + 1'b1;
            end
            prr_pkg::S_IDLE: begin
                if (accept) begin
                    n_seq = i_in.seq_number;
                    n_cnt = i_in.word_count;
                    n_hnd = i_in.payload_handle;
                    n_nres = '0;
                    n_pend_v = 1'b0;
                end
            end
            prr_pkg::S_CLASS: begin
                if (is_drop || is_hit) begin
                    n_pend_v = 1'b1;
                    n_pend_seq = r_seq;
                    n_pend_cnt = r_cnt;
                    n_pend_hnd = r_hnd;
                    n_pend_st = is_drop ? prr_pkg::ST_DROPPED : prr_pkg::ST_RELEASED;
                    n_nres = RW'(1);
                    if (!is_drop) begin
                        n_ne = r_ne + 1'b1;
                        n_eslot = eslot_inc;
                    end
                end else begin
                    o_mem_cmd.re = 1'b1;
                    o_raddr = early_slot;
                    n_slot = early_slot;
                end
            end
            prr_pkg::S_ERD: begin
                if (i_rdata.present) begin
                    // Slot taken: drop the newcomer, keep the stored packet
                    n_pend_v = 1'b1;
                    n_pend_seq = r_seq;
                    n_pend_cnt = r_cnt;
                    n_pend_hnd = r_hnd;
                    n_pend_st = prr_pkg::ST_DROPPED;
                    n_nres = RW'(1);
                end else begin
                    o_mem_cmd.we = 1'b1;
                    o_mem_cmd.wdata = '{present: 1'b1, count: r_cnt, handle: r_hnd};
                    o_waddr = r_slot;
                end
            end
            prr_pkg::S_DRQ: begin
                if (can_drain) begin
                    o_mem_cmd.re = 1'b1;
                    o_raddr = r_eslot;
                end
            end
            prr_pkg::S_DRD: begin
                if (i_rdata.present && (!r_pend_v || push_ok)) begin
                    push = r_pend_v;
                    n_pend_v = 1'b1;
                    n_pend_seq = r_ne;
                    n_pend_cnt = i_rdata.count;
                    n_pend_hnd = i_rdata.handle;
                    n_pend_st = prr_pkg::ST_RELEASED;
                    n_nres = r_nres + 1'b1;
                    o_mem_cmd.we = 1'b1;
                    o_waddr = r_eslot;
                    n_ne = r_ne + 1'b1;
                    n_eslot = eslot_inc;
                end
            end
            prr_pkg::S_FIN: begin
                if (r_pend_v && push_ok) begin
                    push = 1'b1;
                    push_last = 1'b1;
                    n_pend_v = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prr_pkg::S_CLEAR;
            r_clr <= '0;
            r_ne <= '0;
            r_eslot <= '0;
            r_nres <= '0;
            r_pend_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_ne <= n_ne;
            r_eslot <= n_eslot;
            r_nres <= n_nres;
            r_pend_v <= n_pend_v;
            if (push) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq <= n_seq;
        r_cnt <= n_cnt;
        r_hnd <= n_hnd;
        r_slot <= n_slot;
        r_pend_seq <= n_pend_seq;
        r_pend_cnt <= n_pend_cnt;
        r_pend_hnd <= n_pend_hnd;
        r_pend_st <= n_pend_st;
        if (push) begin
            r_out_seq <= r_pend_seq;
            r_out_cnt <= r_pend_cnt;
            r_out_hnd <= r_pend_hnd;
            r_out_st <= r_pend_st;
            r_out_last <= push_last;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.out_seq = r_out_seq;
    assign o_out.out_count = r_out_cnt;
    assign o_out.out_handle = r_out_hnd;
    assign o_out.status = r_out_st;
    assign o_out.last = r_out_last;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !o_out.ready) |-> !push)
        else $error("result register overwritten while stalled");

    a_run_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= RW'(prr_pkg::RUN_CAP))
        else $error("run exceeded the result cap");

    a_ne_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ne != $past(r_ne)) |->
        ($past(r_state) == prr_pkg::S_CLASS || $past(r_state) == prr_pkg::S_DRD))
        else $error("next expected moved outside classify or drain");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_last) |=> (r_state == prr_pkg::S_IDLE && !r_pend_v))
        else $error("final result did not end the transaction");
`endif

endmodule

// ===== hdl/packet_reorder_release.sv =====
// ----------------------------------------------------------------------------
// packet_reorder_release: in-order release of out-of-order packets
// Top level: configuration registers, reorder sequencer and slot store.
// ----------------------------------------------------------------------------
// Packets arrive on i_in with a sequence number, a word count and a payload
// handle, and leave on o_out in sequence order. A packet equal to the next
// expected number is released at once; one that is ahead but within WINDOW
// is parked in slot (seq mod WINDOW) of a single-port-write, registered-read
// slot store and gives no result. Packets behind the window, beyond it, at or
// above total_packets, or hitting an occupied slot come straight back as a
// drop (status 1). After its own packet, every transaction drains stored
// packets in order until the first gap, total_packets, or 64 results; each
// run ends with last set on its final result. After reset the slot store
// is swept clear with i_in.ready low (configuration writes still land).
// Each packet is then accepted and classified; a parked one is written to
// its slot once a read finds the slot free, and every drained stored packet
// is one read and one write-back on the store port pair. A run that stops
// at total_packets or at the 64-result cap rather than at a gap skips the
// final slot read. Output stalls hold the drain and the final result. The
// result register decouples o_out, so a new packet is taken while the last
// result of the previous one still waits.
// total_packets sits at byte address 0; write it only while the block is idle.
// ----------------------------------------------------------------------------
module packet_reorder_release #(
    parameter int WINDOW = prr_pkg::WINDOW_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prr_pkg::PADDR_W-1:0] paddr,
    input  logic [prr_pkg::PDATA_W-1:0] pwdata,
    output logic [prr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    prr_in_if.sink                      i_in,
    prr_out_if.source                   o_out
);

    localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [prr_pkg::SEQ_W-1:0] total;
    prr_pkg::t_mem_cmd         mem_cmd;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [ADDR_W-1:0]         mem_raddr;
    prr_pkg::t_slot_entry      mem_rdata;

    // Hold total_packets for the sequencer
    prr_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_total (total)
    );

    // Classify, park and drain; owns both handshakes and the result register
    prr_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_total   (total),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_mem_cmd (mem_cmd),
        .o_waddr   (mem_waddr),
        .o_raddr   (mem_raddr),
        .i_rdata   (mem_rdata)
    );

    // Present bit, word count and handle per slot; registered read.
    // The sequencer never reads a slot in the cycle after writing it except
    // where it wants the new value, so no bypass is needed.
    prr_slot_mem #(
        .DEPTH (WINDOW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_waddr (mem_waddr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
